### sv/nse_pkg.sv
package nse_pkg;

  // Table geometry
  localparam int MAX_LINES = 64;
  localparam int IDX_W     = $clog2(MAX_LINES);
  localparam int NW        = $clog2(MAX_LINES + 1);

  // Field widths
  localparam int COORD_W   = 16;
  localparam int POINT_W   = 3 * COORD_W;
  localparam int ENTRY_W   = 6;
  localparam int LINES_W   = 7;
  localparam int DIST_W    = 34;
  localparam int SQ_W      = 2 * COORD_W;

  localparam logic [DIST_W-1:0] LIMIT_RESET = 34'd12884901888;

  // Item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_LINES_IN_USE = 1'b0,
    CFG_DIST_LIMIT   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } nse_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_we;
    logic query_start;
    logic scan_step;
    logic out_load;
  } nse_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_zero;
    logic scan_last;
    logic pipe_empty;
    logic out_full;
  } nse_stat_t;

endpackage

### sv/nse_if.sv
interface nse_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     action;
  logic        [nse_pkg::ENTRY_W-1:0]       entry_index;
  logic signed [nse_pkg::COORD_W-1:0]       point_x;
  logic signed [nse_pkg::COORD_W-1:0]       point_y;
  logic signed [nse_pkg::COORD_W-1:0]       point_z;
  logic signed [nse_pkg::COORD_W-1:0]       end_x;
  logic signed [nse_pkg::COORD_W-1:0]       end_y;
  logic signed [nse_pkg::COORD_W-1:0]       end_z;

  modport source (output valid, action, entry_index, point_x, point_y, point_z,
                  end_x, end_y, end_z, input ready);
  modport sink   (input valid, action, entry_index, point_x, point_y, point_z,
                  end_x, end_y, end_z, output ready);
endinterface

interface nse_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [nse_pkg::ENTRY_W-1:0]   line_index;
  logic                          endpoint_end;
  logic [nse_pkg::DIST_W-1:0]    distance_sq;

  modport source (output valid, found, line_index, endpoint_end, distance_sq,
                  input ready);
  modport sink   (input valid, found, line_index, endpoint_end, distance_sq,
                  output ready);
endinterface

### sv/nse_ctrl.sv
module nse_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_action,
  output logic               in_ready,
  input  nse_pkg::nse_stat_t stat,
  output nse_pkg::nse_cmd_t  cmd
);

  nse_pkg::nse_state_t state_r;
  nse_pkg::nse_state_t state_nxt;
  logic                in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nse_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nse_pkg::ST_IDLE: begin
        if (in_fire && in_action == nse_pkg::ACT_QUERY) begin
          state_nxt = stat.n_zero ? nse_pkg::ST_WAIT : nse_pkg::ST_SCAN;
        end
      end
      nse_pkg::ST_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = nse_pkg::ST_WAIT;
        end
      end
      nse_pkg::ST_WAIT: begin
        if (stat.pipe_empty && !stat.out_full) begin
          state_nxt = nse_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd.load_we     = 1'b0;
    cmd.query_start = 1'b0;
    cmd.scan_step   = 1'b0;
    cmd.out_load    = 1'b0;
    case (state_r)
      nse_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.load_we     = in_valid && in_action == nse_pkg::ACT_LOAD;
        cmd.query_start = in_valid && in_action == nse_pkg::ACT_QUERY;
      end
      nse_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      nse_pkg::ST_WAIT: begin
        cmd.out_load = stat.pipe_empty && !stat.out_full;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### sv/nse_dp.sv
module nse_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  nse_pkg::cfg_reg_t                    cfg_index,
  input  logic        [nse_pkg::DIST_W-1:0]    cfg_data,
  // input word payload
  input  logic        [nse_pkg::ENTRY_W-1:0]   entry_index,
  input  logic signed [nse_pkg::COORD_W-1:0]   point_x,
  input  logic signed [nse_pkg::COORD_W-1:0]   point_y,
  input  logic signed [nse_pkg::COORD_W-1:0]   point_z,
  input  logic signed [nse_pkg::COORD_W-1:0]   end_x,
  input  logic signed [nse_pkg::COORD_W-1:0]   end_y,
  input  logic signed [nse_pkg::COORD_W-1:0]   end_z,
  // result word
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_found,
  output logic        [nse_pkg::ENTRY_W-1:0]   out_line_index,
  output logic                                 out_endpoint_end,
  output logic        [nse_pkg::DIST_W-1:0]    out_distance_sq,
  // control
  input  nse_pkg::nse_cmd_t                    cmd,
  output nse_pkg::nse_stat_t                   stat
);

  localparam int IDX_W   = nse_pkg::IDX_W;
  localparam int NW      = nse_pkg::NW;
  localparam int COORD_W = nse_pkg::COORD_W;
  localparam int POINT_W = nse_pkg::POINT_W;
  localparam int DIST_W  = nse_pkg::DIST_W;
  localparam int SQ_W    = nse_pkg::SQ_W;

  function automatic logic [COORD_W-1:0] abs_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] d;
    d = (COORD_W+1)'(a) - (COORD_W+1)'(b);
    if (d < 0) begin
      d = -d;
    end
    return d[COORD_W-1:0];
  endfunction

  // Configuration registers
  logic [nse_pkg::LINES_W-1:0] lines_r;
  logic [DIST_W-1:0]           limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_r <= '0;
      limit_r <= nse_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        nse_pkg::CFG_LINES_IN_USE: lines_r <= cfg_data[nse_pkg::LINES_W-1:0];
        nse_pkg::CFG_DIST_LIMIT:   limit_r <= cfg_data;
        default:                   lines_r <= lines_r;
      endcase
    end
  end

  // Segment tables
  logic [POINT_W-1:0] start_mem [nse_pkg::MAX_LINES];
  logic [POINT_W-1:0] end_mem   [nse_pkg::MAX_LINES];
  logic               wr_ok;

  assign wr_ok = cmd.load_we && (int'(entry_index) < nse_pkg::MAX_LINES);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      start_mem[IDX_W'(entry_index)] <= {point_x, point_y, point_z};
      end_mem[IDX_W'(entry_index)]   <= {end_x, end_y, end_z};
    end
  end

  // Query point and scan position
  logic signed [COORD_W-1:0] qx_r, qy_r, qz_r;
  logic [NW-1:0]             n_eff_r;
  logic [IDX_W-1:0]          ent_r;
  logic                      sel_r;

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      qx_r    <= point_x;
      qy_r    <= point_y;
      qz_r    <= point_z;
      n_eff_r <= (int'(lines_r) > nse_pkg::MAX_LINES) ? NW'(nse_pkg::MAX_LINES)
                                                       : NW'(lines_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
      sel_r <= 1'b0;
    end else if (cmd.query_start) begin
      ent_r <= '0;
      sel_r <= 1'b0;
    end else if (cmd.scan_step) begin
      sel_r <= !sel_r;
      if (sel_r) begin
        ent_r <= ent_r + IDX_W'(1);
      end
    end
  end

  // Stage 1: table read
  logic [POINT_W-1:0] start_rd_r, end_rd_r;
  logic               v1_r, sel1_r;
  logic [IDX_W-1:0]   ent1_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      start_rd_r <= start_mem[ent_r];
      end_rd_r   <= end_mem[ent_r];
    end
    sel1_r <= sel_r;
    ent1_r <= ent_r;
  end

  // Stage 2: absolute coordinate differences
  logic [POINT_W-1:0] pt;
  logic [COORD_W-1:0] a_r [3];
  logic               v2_r, sel2_r;
  logic [IDX_W-1:0]   ent2_r;

  assign pt = sel1_r ? end_rd_r : start_rd_r;

  always_ff @(posedge clk) begin
    a_r[0] <= abs_diff(qx_r, pt[3*COORD_W-1:2*COORD_W]);
    a_r[1] <= abs_diff(qy_r, pt[2*COORD_W-1:COORD_W]);
    a_r[2] <= abs_diff(qz_r, pt[COORD_W-1:0]);
    sel2_r <= sel1_r;
    ent2_r <= ent1_r;
  end

  // Stage 3: squares
  logic [SQ_W-1:0]  sq_r [3];
  logic             v3_r, sel3_r;
  logic [IDX_W-1:0] ent3_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= SQ_W'(a_r[k]) * SQ_W'(a_r[k]);
    end
    sel3_r <= sel2_r;
    ent3_r <= ent2_r;
  end

  // Stage 4: sum of squares
  logic [DIST_W-1:0] dist_r;
  logic              v4_r, sel4_r;
  logic [IDX_W-1:0]  ent4_r;

  always_ff @(posedge clk) begin
    dist_r <= DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
    sel4_r <= sel3_r;
    ent4_r <= ent3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_step;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Running best: strict less-than keeps the earliest candidate on a tie
  logic [DIST_W-1:0] best_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              best_end_r;
  logic              found_r;

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      best_r     <= limit_r;
      best_idx_r <= '0;
      best_end_r <= 1'b0;
      found_r    <= 1'b0;
    end else if (v4_r && dist_r < best_r) begin
      best_r     <= dist_r;
      best_idx_r <= ent4_r;
      best_end_r <= sel4_r;
      found_r    <= 1'b1;
    end
  end

  // Output register
  logic                       out_valid_r;
  logic                       out_found_r;
  logic [nse_pkg::ENTRY_W-1:0] out_idx_r;
  logic                       out_end_r;
  logic [DIST_W-1:0]          out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r <= found_r;
      out_idx_r   <= nse_pkg::ENTRY_W'(best_idx_r);
      out_end_r   <= best_end_r;
      out_dist_r  <= best_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_line_index   = out_idx_r;
  assign out_endpoint_end = out_end_r;
  assign out_distance_sq  = out_dist_r;

  assign stat.n_zero     = (lines_r == '0);
  assign stat.scan_last  = sel_r && (ent_r == IDX_W'(n_eff_r - NW'(1)));
  assign stat.pipe_empty = !(v1_r || v2_r || v3_r || v4_r);
  assign stat.out_full   = out_valid_r && !out_ready;

endmodule

### sv/nearest_segment_endpoint_search.sv
// Nearest segment endpoint search. The block holds a table of 64 line
// segments (start and end point, signed 1/16-unit coordinates) in two
// 64 x 48-bit memories. A load word (action 0) writes one entry. A query
// word (action 1) scans entries 0 .. n-1, n = lines_in_use capped at 64,
// testing the start point and then the end point of each entry through one
// shared squared-distance pipeline (table read, differences, squares, sum,
// compare). That pipeline takes one endpoint per cycle. From acceptance of
// a query until its result word is loaded (the scan, the pipeline drain and
// the result load, or the result load alone when n is zero), the input is
// not ready. The result sits in an output register, so the next word is
// taken while it waits; a later query that finishes while that word still
// waits holds until it is taken. The result reports the entry and endpoint
// with the smallest squared distance below distance_limit_sq (earliest entry
// and start point win ties), or found = 0 with distance_sq equal to the
// limit. Write configuration only while the block is idle. Querying an
// entry never loaded gives undefined fields.
module nearest_segment_endpoint_search (
  input  logic                          clk,
  input  logic                          rst_n,
  nse_in_if.sink                        in_chan,
  nse_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  nse_pkg::cfg_reg_t             cfg_index,
  input  logic [nse_pkg::DIST_W-1:0]    cfg_data
);

  nse_pkg::nse_cmd_t  cmd;
  nse_pkg::nse_stat_t stat;

  // Sequence load, scan, drain and result hand-off
  nse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Tables, distance pipeline, best tracking and output register
  nse_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .entry_index      (in_chan.entry_index),
    .point_x          (in_chan.point_x),
    .point_y          (in_chan.point_y),
    .point_z          (in_chan.point_z),
    .end_x            (in_chan.end_x),
    .end_y            (in_chan.end_y),
    .end_z            (in_chan.end_z),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_found        (out_chan.found),
    .out_line_index   (out_chan.line_index),
    .out_endpoint_end (out_chan.endpoint_end),
    .out_distance_sq  (out_chan.distance_sq),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

### sv/nse_checker.sv
module nse_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_action,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_found,
  input logic [nse_pkg::ENTRY_W-1:0]   out_line_index,
  input logic                          out_endpoint_end,
  input logic [nse_pkg::DIST_W-1:0]    out_distance_sq,
  input logic                          cfg_we,
  input nse_pkg::cfg_reg_t             cfg_index,
  input logic [nse_pkg::DIST_W-1:0]    cfg_data
);

  // Shadow of the distance limit as written on the port
  logic [nse_pkg::DIST_W-1:0] limit_r;
  logic [nse_pkg::DIST_W-1:0] limit_nxt;

  assign limit_nxt = (cfg_we && cfg_index == nse_pkg::CFG_DIST_LIMIT) ? cfg_data : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= nse_pkg::LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found)
      && $stable(out_line_index) && $stable(out_endpoint_end) && $stable(out_distance_sq))
    else $error("result word changed while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == nse_pkg::ACT_QUERY |=> !in_ready)
    else $error("input ready right after a query");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_line_index == '0 && !out_endpoint_end
      && out_distance_sq == limit_r)
    else $error("not-found result fields wrong");

  a_found_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_distance_sq < limit_r)
    else $error("found distance not below limit");

endmodule

bind nearest_segment_endpoint_search nse_checker u_nse_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_action        (in_chan.action),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_found        (out_chan.found),
  .out_line_index   (out_chan.line_index),
  .out_endpoint_end (out_chan.endpoint_end),
  .out_distance_sq  (out_chan.distance_sq),
  .cfg_we           (cfg_we),
  .cfg_index        (cfg_index),
  .cfg_data         (cfg_data)
);
